FILE: rtl/core/cidfl_pkg.sv
// ----------------------------------------------------------------------------
// cidfl_pkg
// Shared request and result types, status codes and controller states of the
// context identifier allocator.
// ----------------------------------------------------------------------------
package cidfl_pkg;

    localparam int unsigned ID_W = 32;

    // Request codes.
    localparam logic FUNC_GET  = 1'b0;
    localparam logic FUNC_FREE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CORRUPTED = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] freed_id;
    } cidfl_req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] granted_id;
    } cidfl_resp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET_DATA,
        S_SCAN,
        S_DONE
    } cidfl_state_t;

endpackage

FILE: rtl/core/cidfl_ram.sv
// ----------------------------------------------------------------------------
// cidfl_ram
// Storage for the free list: one write port and one read port, with the read
// data registered so that it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module cidfl_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [cidfl_pkg::ID_W-1:0]  wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [cidfl_pkg::ID_W-1:0]  rd_data
);
    import cidfl_pkg::*;

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/context_id_free_list_allocator.sv
// Timing: a get served from the list passes through S_GET_DATA to S_DONE; a
// get from the counter, a free of zero or a free into an empty list goes
// straight to S_DONE. Any other free scans the held entries, one entry per
// cycle through the single read port of the free list memory, until a match
// or the last entry. A new request is taken only after S_DONE has passed on.
// Reset: synchronous, active low; counter, pointers, fill count and valid clear.
// ----------------------------------------------------------------------------
// context_id_free_list_allocator
// Hands out context identifiers from a first-in first-out free list, or from a
// running counter when the list is empty, and takes freed identifiers back
// after checking that the list does not already hold them.
// ----------------------------------------------------------------------------
module context_id_free_list_allocator #(
    parameter int unsigned FREE_DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  cidfl_pkg::cidfl_req_t    s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cidfl_pkg::cidfl_resp_t   m_data
);
    import cidfl_pkg::*;

    // Index and fill count widths follow the list depth. The count needs one
    // more value than the index so that a full list can be told from empty.
    localparam int unsigned AW = $clog2(FREE_DEPTH);
    localparam int unsigned CW = $clog2(FREE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(FREE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(FREE_DEPTH);

    // Circular pointer advance; the depth need not be a power of two.
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    cidfl_state_t       state_reg, state_next;
    logic [ID_W-1:0]    highest_reg, highest_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]      scan_left_reg, scan_left_next;
    logic [ID_W-1:0]    id_reg, id_next;
    cidfl_resp_t        res_reg, res_next;
    cidfl_resp_t        m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ID_W-1:0]    ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ID_W-1:0]    ram_rdata;

    logic               accept;
    logic               out_free;
    logic               scan_hit;
    logic               scan_last;

    // The controller takes a new request only when idle. The result register
    // is separate, so a request is accepted even while the previous result
    // still waits for the consumer.
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // During the scan the memory returns, each cycle, the entry addressed in the
    // cycle before. The head entry is read already in the idle cycle, so a
    // get or a scan finds its first entry ready in the following cycle.
    assign ram_raddr = (state_reg == S_SCAN) ? scan_ptr_reg : head_reg;
    assign scan_hit  = (ram_rdata == id_reg);
    assign scan_last = (scan_left_reg == '0);

    cidfl_ram #(
        .DEPTH (FREE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.func == FUNC_GET) begin
                        state_next = (count_reg != '0) ? S_GET_DATA : S_DONE;
                    end else if (s_data.freed_id == '0 || count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_GET_DATA: begin
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        highest_next   = highest_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        id_next        = id_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = id_reg;

        case (state_reg)
            S_IDLE: begin
                ram_wdata = s_data.freed_id;
                if (accept) begin
                    id_next        = s_data.freed_id;
                    scan_ptr_next  = wrap_inc(head_reg);
                    scan_left_next = count_reg - 1'b1;
                    res_next       = '{status: STATUS_OK, granted_id: '0};
                    if (s_data.func == FUNC_GET) begin
                        if (count_reg == '0) begin
                            // Empty list: issue a fresh identifier if any remain.
                            if (highest_reg == ID_MAX) begin
                                res_next.status = STATUS_EXHAUSTED;
                            end else begin
                                highest_next        = highest_reg + 1'b1;
                                res_next.granted_id = highest_reg + 1'b1;
                            end
                        end
                    end else if (s_data.freed_id != '0 && count_reg == '0) begin
                        // Nothing to scan in an empty list: store at once.
                        ram_we     = 1'b1;
                        tail_next  = wrap_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_GET_DATA: begin
                res_next   = '{status: STATUS_OK, granted_id: ram_rdata};
                head_next  = wrap_inc(head_reg);
                count_next = count_reg - 1'b1;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    res_next.status = STATUS_CORRUPTED;
                end else if (scan_last) begin
                    if (count_reg == DEPTH_CNT) begin
                        res_next.status = STATUS_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        tail_next  = wrap_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end else begin
                    scan_ptr_next  = wrap_inc(scan_ptr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            highest_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            highest_reg <= highest_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg  <= scan_ptr_next;
        scan_left_reg <= scan_left_next;
        id_reg        <= id_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("free list fill count exceeds its depth");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (count_reg < DEPTH_CNT))
        else $error("identifier stored into a full free list");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("controller stayed idle after taking a request");

    a_fail_grants_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != STATUS_OK) |-> (m_data_reg.granted_id == '0))
        else $error("refused request carries a nonzero identifier");

    a_counter_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (highest_reg >= $past(highest_reg)))
        else $error("fresh identifier counter moved backward");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the context identifier allocator. It sends get and
// free requests over the s_ channel, predicts each response with an internal
// model of the counter and the first-in first-out free list, and compares the
// responses on the m_ channel field by field. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;
    import cidfl_pkg::*;

    localparam int unsigned LIST_DEPTH   = 16;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned STALL_LIMIT  = 1000;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cidfl_req_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    cidfl_resp_t m_data;

    // Predictor state: the last fresh identifier and the free list contents,
    // oldest entry at the front.
    logic [ID_W-1:0] last_fresh_id = '0;
    logic [ID_W-1:0] held_ids[$];

    // Identifiers handed out and not yet returned; the stimulus frees these.
    logic [ID_W-1:0] granted_pool[$];

    cidfl_resp_t predicted_responses[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int ready_hold     = 0;
    int get_count      = 0;
    int free_count     = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    // When set, neither side inserts gaps, so requests run back to back.
    bit steady_flow = 1'b0;

    context_id_free_list_allocator #(
        .FREE_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (steady_flow) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Computes the response to one accepted request and advances the model.
    // A get pops the oldest held identifier, or else takes the next counter
    // value. A free of zero is dropped, a free of a held identifier is
    // refused as corrupted, and the duplicate check wins over the full check.
    function automatic cidfl_resp_t predict_allocation(cidfl_req_t req);
        cidfl_resp_t rsp;
        bit          already_held;
        rsp.status     = STATUS_OK;
        rsp.granted_id = '0;
        already_held   = 1'b0;
        if (req.func == FUNC_GET) begin
            if (held_ids.size() > 0) begin
                rsp.granted_id = held_ids.pop_front();
            end else if (last_fresh_id == ID_MAX) begin
                rsp.status = STATUS_EXHAUSTED;
            end else begin
                last_fresh_id  = last_fresh_id + 1'b1;
                rsp.granted_id = last_fresh_id;
            end
            if (rsp.status == STATUS_OK) begin
                granted_pool.push_back(rsp.granted_id);
                if (granted_pool.size() > 64) begin
                    void'(granted_pool.pop_front());
                end
            end
        end else if (req.freed_id != '0) begin
            foreach (held_ids[i]) begin
                if (held_ids[i] == req.freed_id) begin
                    already_held = 1'b1;
                end
            end
            if (already_held) begin
                rsp.status = STATUS_CORRUPTED;
            end else if (held_ids.size() >= LIST_DEPTH) begin
                rsp.status = STATUS_FULL;
            end else begin
                held_ids.push_back(req.freed_id);
            end
        end
        return rsp;
    endfunction

    // Sends one request. Valid drops only when a gap precedes the request, so
    // back-to-back requests keep valid high across the handshake edge. The
    // response is predicted at the edge where the request is accepted.
    task automatic send_request(input logic func, input logic [ID_W-1:0] id);
        cidfl_req_t req;
        int         gap;
        req.func     = func;
        req.freed_id = id;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted_responses.push_back(predict_allocation(req));
        if (func == FUNC_GET) begin
            get_count++;
        end else begin
            free_count++;
        end
    endtask

    // Holds the sender off until every outstanding response has come back.
    // Every request yields exactly one response, so an empty queue means the
    // block is idle.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (predicted_responses.size() != 0) @(posedge aclk);
    endtask

    // Fresh identifiers start at one; the identifier field of a get is ignored.
    task automatic test_fresh_ids();
        send_request(FUNC_GET, ID_MAX);
        send_request(FUNC_GET, '0);
    endtask

    // Dropped zero, the all-ones identifier, a duplicate free, and the
    // first-in first-out order of the list on the following gets.
    task automatic test_free_special_cases();
        send_request(FUNC_FREE, '0);
        send_request(FUNC_FREE, ID_MAX);
        send_request(FUNC_FREE, 32'd2);
        send_request(FUNC_FREE, 32'd2);
        send_request(FUNC_GET, 32'h5A5A_5A5A);
        send_request(FUNC_GET, '0);
    endtask

    // Fills the list through a pointer wrap, then frees into the full list
    // once with a new identifier and once with one it already holds. Each
    // stored identifier sets two adjacent bits, so all 32 bits get used.
    task automatic test_full_list();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            send_request(FUNC_FREE, 32'h3 << (2 * k));
        end
        send_request(FUNC_FREE, 32'h1234_5678);
        send_request(FUNC_FREE, 32'h3);
    endtask

    // Mixed traffic in phases with different free ratios, so the list runs
    // from empty to full and its pointers wrap many times. Frees mostly
    // return identifiers that were handed out, some repeat a held one, some
    // are zero and the rest are arbitrary values. Each phase ends with the
    // sender paused until all responses are in. Counter exhaustion needs
    // four billion fresh gets and lies beyond any run.
    task automatic test_random_traffic();
        int              free_pct[6] = '{30, 50, 70, 50, 85, 40};
        int              per_phase;
        int              roll;
        int              pick;
        logic [ID_W-1:0] id;
        per_phase = RANDOM_ITEMS / 6;
        for (int phase = 0; phase < 6; phase++) begin
            steady_flow = (phase == 3);
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 99) >= free_pct[phase]) begin
                    send_request(FUNC_GET, $urandom);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55 && granted_pool.size() > 0) begin
                        pick = $urandom_range(0, granted_pool.size() - 1);
                        id   = granted_pool[pick];
                        granted_pool.delete(pick);
                    end else if (roll < 75 && held_ids.size() > 0) begin
                        id = held_ids[$urandom_range(0, held_ids.size() - 1)];
                    end else if (roll < 83) begin
                        id = '0;
                    end else begin
                        id = $urandom;
                    end
                    send_request(FUNC_FREE, id);
                end
            end
            wait_for_results();
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: ready is high for one cycle, then may drop for a random stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // Compares every accepted response with the oldest prediction.
    always @(posedge aclk) begin : check_responses
        cidfl_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_data.status]++;
            if (predicted_responses.size() == 0) begin
                $error("unexpected response: status %0d, granted_id 0x%08h",
                       m_data.status, m_data.granted_id);
                mismatch_count++;
            end else begin
                want = predicted_responses.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.granted_id !== want.granted_id) begin
                    $error("granted_id: expected 0x%08h, actual 0x%08h",
                           want.granted_id, m_data.granted_id);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither channel completes a handshake for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles, %0d responses outstanding",
                   quiet_cycles, predicted_responses.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fresh_ids();
        test_free_special_cases();
        test_full_list();
        test_random_traffic();

        wait_for_results();
        repeat (LIST_DEPTH + 4) @(posedge aclk);

        $display("Sent %0d requests: %0d gets and %0d frees, with random gaps and stalls.",
                 get_count + free_count, get_count, free_count);
        $display("Responses by status: %0d ok, %0d duplicate, %0d list full, %0d exhausted.",
                 status_seen[STATUS_OK], status_seen[STATUS_CORRUPTED],
                 status_seen[STATUS_FULL], status_seen[STATUS_EXHAUSTED]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
